// ===== design/yfvr_pkg.sv =====
// shared types, constants and helpers for the yuv fade block
`timescale 1ns / 1ps
`default_nettype none

package yfvr_pkg;

  // sample and packing sizes
  localparam int unsigned ByteW    = 8;
  localparam int unsigned MaxLanes = 8;
  localparam int unsigned WordW    = ByteW * MaxLanes;

  // configuration port
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  // register index, taken from paddr bit 2
  typedef enum logic {
    RegFadeLevel = 1'b0
  } yfvr_reg_e;

  localparam logic [ByteW-1:0] FadeReset = 8'd255;

  // signed q8 working sum, wide enough for every channel sum
  localparam int unsigned SumW = 20;
  typedef logic signed [SumW-1:0] sum_t;

  // yuv to rgb coefficients, q8
  localparam sum_t CoefRv = 20'sd359;
  localparam sum_t CoefGu = 20'sd88;
  localparam sum_t CoefGv = 20'sd183;
  localparam sum_t CoefBu = 20'sd454;

  // rgb to yuv coefficients, q8
  localparam sum_t CoefYr = 20'sd77;
  localparam sum_t CoefYg = 20'sd150;
  localparam sum_t CoefYb = 20'sd29;
  localparam sum_t CoefUr = 20'sd43;
  localparam sum_t CoefUg = 20'sd85;
  localparam sum_t CoefUb = 20'sd128;
  localparam sum_t CoefVr = 20'sd128;
  localparam sum_t CoefVg = 20'sd107;
  localparam sum_t CoefVb = 20'sd21;

  localparam sum_t ChromaOfs = 20'sd128;
  localparam sum_t RoundHalf = 20'sd128;
  localparam sum_t ChromaQ8  = 20'sd32768;

  // one pixel, three 8-bit samples
  typedef struct packed {
    logic [ByteW-1:0] y;
    logic [ByteW-1:0] u;
    logic [ByteW-1:0] v;
  } yfvr_pix_t;

  // stage load enables handed to the lanes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } yfvr_adv_t;

  // floor a biased q8 sum to an integer and saturate to 0..255
  function automatic logic [ByteW-1:0] q8_sat(input sum_t t);
    logic [ByteW-1:0] r;
    if (t < 0) begin
      r = '0;
    end else if (t[SumW-1:16] != '0) begin
      r = '1;
    end else begin
      r = t[15:8];
    end
    return r;
  endfunction

  // widen an unsigned sample into the working sum
  function automatic sum_t to_sum(input logic [ByteW-1:0] s);
    return sum_t'({1'b0, s});
  endfunction

endpackage

`default_nettype wire

// ===== design/yuv_fade_via_rgb.sv =====
// top level: yuv fade through rgb, parallel pixel lanes and output merge
//
//   channel  direction  signals                               word
//   in       to block   in_valid_i in_ready_o                 luma_in_i cb_in_i cr_in_i
//   out      from block out_valid_o out_ready_i               luma_out_o cb_out_o cr_out_o
//   cfg      to block   psel penable pwrite paddr pwdata      prdata pready
//
// one word per cycle sustained while out_ready_i stays high; a taken word passes
// through the three lane stages and then the output register
// each stage loads when it is empty or its successor loads, so bubbles close up
// and a new word is taken while a finished one waits at the output
// rst_ni clears the stage valids and sets fade_level to 255
`timescale 1ns / 1ps
`default_nettype none

module yuv_fade_via_rgb #(
  parameter int unsigned LANES = 8
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // input words
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [yfvr_pkg::WordW-1:0]        luma_in_i,
  input  wire  [yfvr_pkg::WordW-1:0]        cb_in_i,
  input  wire  [yfvr_pkg::WordW-1:0]        cr_in_i,
  // output words
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [yfvr_pkg::WordW-1:0]        luma_out_o,
  output logic [yfvr_pkg::WordW-1:0]        cb_out_o,
  output logic [yfvr_pkg::WordW-1:0]        cr_out_o,
  // configuration
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [yfvr_pkg::AddrW-1:0]        paddr,
  input  wire  [yfvr_pkg::DataW-1:0]        pwdata,
  output logic [yfvr_pkg::DataW-1:0]        prdata,
  output logic                              pready
);
  import yfvr_pkg::*;

  logic [ByteW-1:0] fade_q, fade_d;
  logic             cfg_wr;
  yfvr_reg_e        reg_sel;

  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;
  logic load1, load2, load3, load4;
  yfvr_adv_t adv;

  yfvr_pix_t [LANES-1:0] lane_in;
  yfvr_pix_t [LANES-1:0] lane_out;

  // register decode
  assign reg_sel = yfvr_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    fade_d = fade_q;
    if (cfg_wr && (reg_sel == RegFadeLevel)) begin
      fade_d = pwdata[ByteW-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegFadeLevel: prdata = {{(DataW-ByteW){1'b0}}, fade_q};
      default:      prdata = '0;
    endcase
  end

  // stage loads: empty or the next stage moves
  assign load4 = !v4_q || out_ready_i;
  assign load3 = !v3_q || load4;
  assign load2 = !v2_q || load3;
  assign load1 = !v1_q || load2;

  assign adv.s1 = load1;
  assign adv.s2 = load2;
  assign adv.s3 = load3;

  assign v1_d = load1 ? in_valid_i : v1_q;
  assign v2_d = load2 ? v1_q : v2_q;
  assign v3_d = load3 ? v2_q : v3_q;
  assign v4_d = load4 ? v3_q : v4_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_q <= FadeReset;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
    end else begin
      fade_q <= fade_d;
      v1_q   <= v1_d;
      v2_q   <= v2_d;
      v3_q   <= v3_d;
      v4_q   <= v4_d;
    end
  end

  assign in_ready_o  = load1;
  assign out_valid_o = v4_q;

  // pixel lanes
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign lane_in[i].y = luma_in_i[i*ByteW +: ByteW];
    assign lane_in[i].u = cb_in_i[i*ByteW +: ByteW];
    assign lane_in[i].v = cr_in_i[i*ByteW +: ByteW];

    yfvr_lane u_lane (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .fade_i (fade_q),
      .pix_i  (lane_in[i]),
      .pix_o  (lane_out[i])
    );
  end

  // merge into output words
  yfvr_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i  (clk_i),
    .load_i (load4),
    .pix_i  (lane_out),
    .luma_o (luma_out_o),
    .cb_o   (cb_out_o),
    .cr_o   (cr_out_o)
  );

`ifndef SYNTH
  // an accepted word always occupies the first stage next cycle
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted word lost at stage 1");

  // an empty first stage never refuses a word
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> in_ready_o)
    else $error("input stalled with empty stage 1");

  // a finished word moves into an empty output register
  a_drain_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !v4_q |=> v4_q)
    else $error("stage 3 word did not reach output");

  // a fade write lands in the register
  a_fade_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && (reg_sel == RegFadeLevel) |=> fade_q == $past(pwdata[ByteW-1:0]))
    else $error("fade level write not taken");
`endif

endmodule

`default_nettype wire

// ===== design/yfvr_lane.sv =====
// one pixel lane: yuv to rgb, fade, rgb to yuv over three stages
`timescale 1ns / 1ps
`default_nettype none

module yfvr_lane (
  input  wire                           clk_i,
  input  yfvr_pkg::yfvr_adv_t           adv_i,
  input  wire  [yfvr_pkg::ByteW-1:0]    fade_i,
  input  yfvr_pkg::yfvr_pix_t           pix_i,
  output yfvr_pkg::yfvr_pix_t           pix_o
);
  import yfvr_pkg::*;

  logic [ByteW-1:0] r1_q, g1_q, b1_q;
  logic [ByteW-1:0] r1_d, g1_d, b1_d;
  logic [ByteW-1:0] r2_q, g2_q, b2_q;
  logic [ByteW-1:0] r2_d, g2_d, b2_d;
  yfvr_pix_t        pix3_q, pix3_d;

  // stage 1: yuv to rgb with saturation
  always_comb begin
    sum_t ys, du, dv;
    ys   = sum_t'({4'd0, pix_i.y, 8'd0});
    du   = to_sum(pix_i.u) - ChromaOfs;
    dv   = to_sum(pix_i.v) - ChromaOfs;
    r1_d = q8_sat(ys + CoefRv * dv + RoundHalf);
    g1_d = q8_sat(ys - CoefGu * du - CoefGv * dv + RoundHalf);
    b1_d = q8_sat(ys + CoefBu * du + RoundHalf);
  end

  // stage 2: scale by fade level over 256, rounded
  always_comb begin
    logic [15:0] pr, pg, pb;
    pr   = ({8'd0, r1_q} * {8'd0, fade_i}) + 16'd128;
    pg   = ({8'd0, g1_q} * {8'd0, fade_i}) + 16'd128;
    pb   = ({8'd0, b1_q} * {8'd0, fade_i}) + 16'd128;
    r2_d = pr[15:8];
    g2_d = pg[15:8];
    b2_d = pb[15:8];
  end

  // stage 3: rgb back to yuv, chroma offset 128
  always_comb begin
    sum_t r, g, b;
    r        = to_sum(r2_q);
    g        = to_sum(g2_q);
    b        = to_sum(b2_q);
    pix3_d.y = q8_sat(CoefYr * r + CoefYg * g + CoefYb * b + RoundHalf);
    pix3_d.u = q8_sat(CoefUb * b - CoefUr * r - CoefUg * g + ChromaQ8 + RoundHalf);
    pix3_d.v = q8_sat(CoefVr * r - CoefVg * g - CoefVb * b + ChromaQ8 + RoundHalf);
  end

  // stage registers, payload only
  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      r1_q <= r1_d;
      g1_q <= g1_d;
      b1_q <= b1_d;
    end
    if (adv_i.s2) begin
      r2_q <= r2_d;
      g2_q <= g2_d;
      b2_q <= b2_d;
    end
    if (adv_i.s3) begin
      pix3_q <= pix3_d;
    end
  end

  assign pix_o = pix3_q;

endmodule

`default_nettype wire

// ===== design/yfvr_merge.sv =====
// packs the lane results into the output words, unused bytes zero
`timescale 1ns / 1ps
`default_nettype none

module yfvr_merge #(
  parameter int unsigned LANES = 8
) (
  input  wire                                clk_i,
  input  wire                                load_i,
  input  yfvr_pkg::yfvr_pix_t [LANES-1:0]    pix_i,
  output logic [yfvr_pkg::WordW-1:0]         luma_o,
  output logic [yfvr_pkg::WordW-1:0]         cb_o,
  output logic [yfvr_pkg::WordW-1:0]         cr_o
);
  import yfvr_pkg::*;

  logic [WordW-1:0] luma_q, luma_d;
  logic [WordW-1:0] cb_q, cb_d;
  logic [WordW-1:0] cr_q, cr_d;

  // byte i of each word comes from lane i
  always_comb begin
    luma_d = '0;
    cb_d   = '0;
    cr_d   = '0;
    for (int unsigned i = 0; i < LANES; i++) begin
      luma_d[i*ByteW +: ByteW] = pix_i[i].y;
      cb_d[i*ByteW +: ByteW]   = pix_i[i].u;
      cr_d[i*ByteW +: ByteW]   = pix_i[i].v;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      luma_q <= luma_d;
      cb_q   <= cb_d;
      cr_q   <= cr_d;
    end
  end

  assign luma_o = luma_q;
  assign cb_o   = cb_q;
  assign cr_o   = cr_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_yuv_fade_via_rgb.sv =====
// testbench for the yuv fade block: random and directed words checked against a predictor
`timescale 1ns / 1ps

module tb_yuv_fade_via_rgb;
  import yfvr_pkg::*;

  localparam int unsigned Lanes          = 8;
  localparam int unsigned PipeLatency    = 4;
  localparam int unsigned SinkHoldCycles = 60;
  localparam int unsigned PhaseWords     = 75;
  localparam int unsigned MaxReports     = 40;
  localparam int unsigned IdlePct        = 9;
  localparam longint     TimeoutNs       = 400_000;

  // register addresses, index in paddr bit 2
  localparam logic [AddrW-1:0] FadeAddr  = {RegFadeLevel, 2'b00};
  localparam logic [AddrW-1:0] SpareAddr = 3'b100;  // index 1, no register there

  typedef struct packed {
    logic [WordW-1:0] y;
    logic [WordW-1:0] u;
    logic [WordW-1:0] v;
  } yuv_word_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic [WordW-1:0] luma_in_i   = '0;
  logic [WordW-1:0] cb_in_i     = '0;
  logic [WordW-1:0] cr_in_i     = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [WordW-1:0] luma_out_o;
  logic [WordW-1:0] cb_out_o;
  logic [WordW-1:0] cr_out_o;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [AddrW-1:0] paddr       = '0;
  logic [DataW-1:0] pwdata      = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  yuv_word_t   yuv_words_q[$];    // words waiting to be offered
  yuv_word_t   faded_words_q[$];  // predicted results, oldest first
  yuv_word_t   next_word;
  logic [7:0]  level_shadow = FadeReset;
  logic        in_taken     = 1'b0;
  logic        src_gaps     = 1'b1;
  logic        sink_gaps    = 1'b1;
  int unsigned stall_reqs   = 0;
  int unsigned stall_done   = 0;
  int unsigned hold_left    = 0;
  int unsigned mismatch_cnt = 0;

  yuv_fade_via_rgb #(
    .LANES(Lanes)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .luma_in_i  (luma_in_i),
    .cb_in_i    (cb_in_i),
    .cr_in_i    (cr_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .luma_out_o (luma_out_o),
    .cb_out_o   (cb_out_o),
    .cr_out_o   (cr_out_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // clock and reset
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // floor a biased q8 sum to a byte, saturating
  function automatic logic [7:0] clamp_q8(input int t);
    if (t < 0) begin
      return 8'd0;
    end else if ((t >>> 8) > 255) begin
      return 8'd255;
    end
    return t[15:8];
  endfunction

  // yuv -> rgb, scale by level/256, rgb -> yuv, per pixel lane
  function automatic yuv_word_t fade_words(input yuv_word_t src, input logic [7:0] level);
    yuv_word_t res;
    int        ys;
    int        du;
    int        dv;
    int        r;
    int        g;
    int        b;
    res = '0;
    for (int i = 0; i < Lanes; i++) begin
      ys = int'(src.y[i*8 +: 8]) * 256;
      du = int'(src.u[i*8 +: 8]) - 128;
      dv = int'(src.v[i*8 +: 8]) - 128;
      r  = int'(clamp_q8(ys + 359 * dv + 128));
      g  = int'(clamp_q8(ys - 88 * du - 183 * dv + 128));
      b  = int'(clamp_q8(ys + 454 * du + 128));
      // fade, rounded to nearest
      r  = (r * int'(level) + 128) >>> 8;
      g  = (g * int'(level) + 128) >>> 8;
      b  = (b * int'(level) + 128) >>> 8;
      res.y[i*8 +: 8] = clamp_q8(77 * r + 150 * g + 29 * b + 128);
      res.u[i*8 +: 8] = clamp_q8(-43 * r - 85 * g + 128 * b + 32768 + 128);
      res.v[i*8 +: 8] = clamp_q8(128 * r - 107 * g - 21 * b + 32768 + 128);
    end
    return res;
  endfunction

  // random word, bytes leaning toward the saturation corners and toward mid-scale 0x80
  function automatic logic [WordW-1:0] pick_samples();
    logic [WordW-1:0] w;
    int unsigned      k;
    for (int i = 0; i < MaxLanes; i++) begin
      k = $urandom_range(9);
      if (k < 7) begin
        w[i*8 +: 8] = 8'($urandom);
      end else if (k == 7) begin
        w[i*8 +: 8] = 8'h00;
      end else if (k == 8) begin
        w[i*8 +: 8] = 8'hff;
      end else begin
        w[i*8 +: 8] = 8'h80 ^ 8'($urandom_range(3));
      end
    end
    return w;
  endfunction

  task automatic flag_mismatch(input string what, input logic [WordW-1:0] got,
                               input logic [WordW-1:0] want);
    if (mismatch_cnt < MaxReports) begin
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    end
    mismatch_cnt++;
  endtask

  task automatic queue_word(input logic [WordW-1:0] y, input logic [WordW-1:0] u,
                            input logic [WordW-1:0] v);
    yuv_word_t w;
    w.y = y;
    w.u = u;
    w.v = v;
    yuv_words_q.push_back(w);
  endtask

  // wait until every queued word is taken and every result is back
  task automatic wait_drained();
    while (yuv_words_q.size() != 0 || in_valid_i || faded_words_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PipeLatency + 2) @(posedge clk_i);
  endtask

  // config write, setup then access
  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (yfvr_reg_e'(addr[2]) == RegFadeLevel) begin
      level_shadow = data[7:0];
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // config read of the fade level, compared with the shadow copy
  task automatic check_level();
    logic [DataW-1:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= FadeAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    if (got[7:0] !== level_shadow) begin
      flag_mismatch("fade_level", WordW'(got[7:0]), WordW'(level_shadow));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_level(input logic [7:0] level);
    apb_write(FadeAddr, {24'($urandom), level});
    check_level();
  endtask

  // input acceptance and prediction
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (in_taken) begin
      faded_words_q.push_back(fade_words({luma_in_i, cb_in_i, cr_in_i}, level_shadow));
    end
  end

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (yuv_words_q.size() != 0 && !(src_gaps && $urandom_range(99) < IdlePct)) begin
        next_word = yuv_words_q.pop_front();
        luma_in_i  <= next_word.y;
        cb_in_i    <= next_word.u;
        cr_in_i    <= next_word.v;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output ready, random stalls and the long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_reqs != stall_done) begin
      stall_done++;
      hold_left = SinkHoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(sink_gaps && $urandom_range(99) < IdlePct);
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    yuv_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (faded_words_q.size() == 0) begin
        flag_mismatch("unexpected word", luma_out_o, '0);
      end else begin
        want = faded_words_q.pop_front();
        if (luma_out_o !== want.y) flag_mismatch("luma_out", luma_out_o, want.y);
        if (cb_out_o !== want.u) flag_mismatch("cb_out", cb_out_o, want.u);
        if (cr_out_o !== want.v) flag_mismatch("cr_out", cr_out_o, want.v);
      end
    end
  end

  // run limit
  initial begin
    #(TimeoutNs * 1ns);
    $display("status: fail");
    $finish;
  end

  // stimulus
  initial begin
    logic [7:0] phase_level;
    @(posedge rst_ni);
    check_level();

    // corners at the reset level
    queue_word('0, '0, '0);
    queue_word('1, '1, '1);
    queue_word({8{8'hff}}, {8{8'h80}}, {8{8'h80}});
    queue_word('0, {8{8'h80}}, {8{8'h80}});
    queue_word({8{8'hff}}, {8{8'h80}}, {8{8'hff}});  // red over the top
    queue_word('0, {8{8'h80}}, '0);                  // red below zero
    queue_word({8{8'hff}}, {8{8'hff}}, {8{8'h80}});  // blue over the top
    queue_word('0, '0, {8{8'h80}});                  // blue below zero
    queue_word('0, '1, '1);                          // green below zero
    queue_word('1, '0, '0);                          // green over the top, red and blue in range
    queue_word(64'hf0d0_b090_7050_3010, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    queue_word({8{8'haa}}, {8{8'h55}}, {8{8'haa}});
    wait_drained();

    // write to the spare index is dropped
    apb_write(SpareAddr, 32'h0000_0010);
    check_level();
    queue_word({8{8'h9c}}, {8{8'h31}}, {8{8'hd7}});
    queue_word({8{8'h55}}, {8{8'haa}}, {8{8'h55}});
    wait_drained();

    // only the low byte of a wide value lands: level 0
    apb_write(FadeAddr, 32'hffff_ff00);
    check_level();
    queue_word('1, '1, '1);
    queue_word({8{8'h80}}, {8{8'h80}}, {8{8'h80}});
    queue_word('0, '0, '0);
    wait_drained();

    // half level, odd channels exercise the fade rounding
    set_level(8'd128);
    queue_word({8{8'h81}}, {8{8'h80}}, {8{8'h80}});
    queue_word(64'h0103_0507_090b_0d0f, {8{8'h7f}}, {8{8'h81}});
    queue_word({8{8'hfe}}, {8{8'h01}}, {8{8'hfe}});
    wait_drained();

    set_level(8'd1);
    queue_word('1, {8{8'h80}}, {8{8'h80}});
    queue_word({8{8'hff}}, {8{8'hff}}, {8{8'hff}});
    queue_word({8{8'h7f}}, {8{8'h00}}, {8{8'hff}});
    wait_drained();

    // random phases across several levels
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: phase_level = 8'd128;
        1: phase_level = 8'd255;
        2: phase_level = 8'($urandom_range(2, 253));
        3: phase_level = 8'd0;
        4: phase_level = 8'd1;
        default: phase_level = 8'($urandom_range(2, 253));
      endcase
      set_level(phase_level);
      // one phase runs back to back on both sides with a long output hold-off
      src_gaps  = (p != 2);
      sink_gaps = (p != 2);
      for (int n = 0; n < PhaseWords; n++) begin
        queue_word(pick_samples(), pick_samples(), pick_samples());
      end
      if (p == 2) begin
        @(posedge clk_i);
        stall_reqs++;
      end
      wait_drained();
    end

    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
